// ===== rtl/assert_macros.svh =====
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold whenever the antecedent holds
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/tsm_pkg.sv =====
// types, codes and constants of the time signature map
package tsm_pkg;

  localparam int unsigned BarTicks = 1920;
  localparam int unsigned DefSig   = 4;
  localparam int unsigned SigW     = 8;
  localparam int unsigned BarW     = 20;
  localparam int unsigned InTickW  = 32;
  localparam int unsigned TickW    = 48;
  localparam int unsigned ResBarW  = 32;
  localparam int unsigned SpanW    = 19;
  localparam int unsigned DivW     = 49;
  localparam int unsigned DivCntW  = 6;
  localparam int unsigned LutW     = 11;

  typedef enum logic [1:0] {
    OP_PUSH        = 2'd0,
    OP_BAR_AT_TICK = 2'd1,
    OP_TICK_AT_BAR = 2'd2,
    OP_READ        = 2'd3
  } op_e;

  typedef struct packed {
    logic [SigW-1:0]  num;
    logic [SigW-1:0]  den;
    logic [BarW-1:0]  bar;
    logic [TickW-1:0] tick;
  } entry_t;

  typedef enum logic [4:0] {
    ACT_NONE, ACT_LATCH, ACT_RD_I, ACT_RD_JM1, ACT_RD_0, ACT_RD_IDX,
    ACT_P_CMP, ACT_P_APP, ACT_X_ERR, ACT_X_OUT, ACT_I_ONE, ACT_S_LDI,
    ACT_S_PUT, ACT_S_CMP, ACT_R_LD0, ACT_R_SPAN, ACT_R_MUL, ACT_R_WR,
    ACT_SET_FRESH, ACT_L_INIT, ACT_L_CMP, ACT_L_SPAN, ACT_DIV_START,
    ACT_DIV_STEP, ACT_L_BAR, ACT_L_MUL, ACT_L_TICK, ACT_FIN
  } dp_act_e;

  typedef struct packed {
    op_e  op;
    logic fresh;
    logic cnt_zero;
    logic i_lt_cnt;
    logic match;
    logic gt;
    logic j_zero;
    logic idx_ok;
    logic div_last;
  } dp_status_t;

  typedef logic [LutW-1:0] bar_lut_t [256];

  // whole-bar ticks divided by the denominator, zero for a zero denominator
  function automatic bar_lut_t build_bar_lut();
    bar_lut_t    l;
    int unsigned q;
    int unsigned r;
    l[0] = '0;
    for (int unsigned d = 1; d < 256; d++) begin
      q = 0;
      r = BarTicks;
      while (r >= d) begin
        r = r - d;
        q++;
      end
      l[d] = LutW'(q);
    end
    return l;
  endfunction

  localparam bar_lut_t BarDivLut = build_bar_lut();

endpackage

// ===== rtl/time_signature_map_core.sv =====
// time signature map top level: controller plus datapath
//
// channel   direction  handshake
// command   in         start with busy low; op_i, sig_*_i, bar_in_i, tick_in_i, entry_index_i
// result    out        done_o for one cycle; res_*_o, entry_count_o, up_to_date_o, error_o
//
// one item at a time; busy stays high from the accepted start until done_o
// push: scans the entries for a matching bar, then updates it or appends; read entry: reads
// the indexed entry or flags an error when out of range; lookups: a scan of the entries, then
// a 49-step shift-subtract divider, after an insertion sort and a per-entry recompute when stale
// the entry memory has one read and one write port; the result beat is never held off
// reset clears count and up-to-date flag; entries are undefined until written
module time_signature_map_core #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op_i,
  input  logic [7:0]  sig_num_i,
  input  logic [7:0]  sig_den_i,
  input  logic [19:0] bar_in_i,
  input  logic [31:0] tick_in_i,
  input  logic [3:0]  entry_index_i,
  output logic        done_o,
  output logic [7:0]  res_num_o,
  output logic [7:0]  res_den_o,
  output logic [31:0] res_bar_o,
  output logic [47:0] res_tick_o,
  output logic [4:0]  entry_count_o,
  output logic        up_to_date_o,
  output logic        error_o
);
  import tsm_pkg::*;

  `include "assert_macros.svh"

  dp_act_e    act;
  dp_status_t status;

  tsm_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .status_i (status),
    .act_o    (act),
    .busy     (busy)
  );

  tsm_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .act_i         (act),
    .op_i          (op_i),
    .sig_num_i     (sig_num_i),
    .sig_den_i     (sig_den_i),
    .bar_in_i      (bar_in_i),
    .tick_in_i     (tick_in_i),
    .entry_index_i (entry_index_i),
    .status_o      (status),
    .done_o        (done_o),
    .res_num_o     (res_num_o),
    .res_den_o     (res_den_o),
    .res_bar_o     (res_bar_o),
    .res_tick_o    (res_tick_o),
    .entry_count_o (entry_count_o),
    .up_to_date_o  (up_to_date_o),
    .error_o       (error_o)
  );

  `ASSERT_IMPL(a_done_idle, clk_i, rst_ni, done_o, !busy)
  `ASSERT_NEXT(a_start_busy, clk_i, rst_ni, start && !busy, busy)
  `ASSERT_NEXT(a_done_single, clk_i, rst_ni, done_o, !done_o)

endmodule

// ===== rtl/tsm_ctrl.sv =====
// sequencing state machine of the time signature map
module tsm_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  tsm_pkg::dp_status_t status_i,
  output tsm_pkg::dp_act_e    act_o,
  output logic                busy
);
  import tsm_pkg::*;

  typedef enum logic [24:0] {
    ST_IDLE   = 25'h0000001, ST_DISP   = 25'h0000002, ST_P_CHK  = 25'h0000004,
    ST_P_CMP  = 25'h0000008, ST_X_CHK  = 25'h0000010, ST_X_OUT  = 25'h0000020,
    ST_S_CHK  = 25'h0000040, ST_S_LDI  = 25'h0000080, ST_S_JCHK = 25'h0000100,
    ST_S_CMPJ = 25'h0000200, ST_R_RD0  = 25'h0000400, ST_R_LD0  = 25'h0000800,
    ST_R_CHK  = 25'h0001000, ST_R_SPAN = 25'h0002000, ST_R_MUL  = 25'h0004000,
    ST_R_WR   = 25'h0008000, ST_L_INIT = 25'h0010000, ST_L_CHK  = 25'h0020000,
    ST_L_CMP  = 25'h0040000, ST_L_SPAN = 25'h0080000, ST_L_DSET = 25'h0100000,
    ST_L_DIV  = 25'h0200000, ST_L_POST = 25'h0400000, ST_L_ADD  = 25'h0800000,
    ST_FIN    = 25'h1000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    act_o   = ACT_NONE;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          act_o   = ACT_LATCH;
          state_d = ST_DISP;
        end
      end
      ST_DISP: begin
        if (status_i.op == OP_PUSH) begin
          state_d = ST_P_CHK;
        end else if (status_i.op == OP_READ) begin
          state_d = ST_X_CHK;
        end else if (!status_i.fresh && !status_i.cnt_zero) begin
          act_o   = ACT_I_ONE;
          state_d = ST_S_CHK;
        end else begin
          state_d = ST_L_INIT;
        end
      end
      ST_P_CHK: begin
        if (status_i.i_lt_cnt) begin
          act_o   = ACT_RD_I;
          state_d = ST_P_CMP;
        end else begin
          act_o   = ACT_P_APP;
          state_d = ST_FIN;
        end
      end
      ST_P_CMP: begin
        act_o   = ACT_P_CMP;
        state_d = status_i.match ? ST_FIN : ST_P_CHK;
      end
      ST_X_CHK: begin
        if (status_i.idx_ok) begin
          act_o   = ACT_RD_IDX;
          state_d = ST_X_OUT;
        end else begin
          act_o   = ACT_X_ERR;
          state_d = ST_FIN;
        end
      end
      ST_X_OUT: begin
        act_o   = ACT_X_OUT;
        state_d = ST_FIN;
      end
      ST_S_CHK: begin
        if (status_i.i_lt_cnt) begin
          act_o   = ACT_RD_I;
          state_d = ST_S_LDI;
        end else begin
          state_d = ST_R_RD0;
        end
      end
      ST_S_LDI: begin
        act_o   = ACT_S_LDI;
        state_d = ST_S_JCHK;
      end
      ST_S_JCHK: begin
        if (status_i.j_zero) begin
          act_o   = ACT_S_PUT;
          state_d = ST_S_CHK;
        end else begin
          act_o   = ACT_RD_JM1;
          state_d = ST_S_CMPJ;
        end
      end
      ST_S_CMPJ: begin
        act_o   = ACT_S_CMP;
        state_d = status_i.gt ? ST_S_JCHK : ST_S_CHK;
      end
      ST_R_RD0: begin
        act_o   = ACT_RD_0;
        state_d = ST_R_LD0;
      end
      ST_R_LD0: begin
        act_o   = ACT_R_LD0;
        state_d = ST_R_CHK;
      end
      ST_R_CHK: begin
        if (status_i.i_lt_cnt) begin
          act_o   = ACT_RD_I;
          state_d = ST_R_SPAN;
        end else begin
          act_o   = ACT_SET_FRESH;
          state_d = ST_L_INIT;
        end
      end
      ST_R_SPAN: begin
        act_o   = ACT_R_SPAN;
        state_d = ST_R_MUL;
      end
      ST_R_MUL: begin
        act_o   = ACT_R_MUL;
        state_d = ST_R_WR;
      end
      ST_R_WR: begin
        act_o   = ACT_R_WR;
        state_d = ST_R_CHK;
      end
      ST_L_INIT: begin
        act_o   = ACT_L_INIT;
        state_d = ST_L_CHK;
      end
      ST_L_CHK: begin
        if (status_i.i_lt_cnt) begin
          act_o   = ACT_RD_I;
          state_d = ST_L_CMP;
        end else begin
          state_d = ST_L_SPAN;
        end
      end
      ST_L_CMP: begin
        act_o   = ACT_L_CMP;
        state_d = ST_L_CHK;
      end
      ST_L_SPAN: begin
        act_o   = ACT_L_SPAN;
        state_d = ST_L_DSET;
      end
      ST_L_DSET: begin
        act_o   = ACT_DIV_START;
        state_d = ST_L_DIV;
      end
      ST_L_DIV: begin
        act_o   = ACT_DIV_STEP;
        if (status_i.div_last) state_d = ST_L_POST;
      end
      ST_L_POST: begin
        if (status_i.op == OP_BAR_AT_TICK) begin
          act_o   = ACT_L_BAR;
          state_d = ST_FIN;
        end else begin
          act_o   = ACT_L_MUL;
          state_d = ST_L_ADD;
        end
      end
      ST_L_ADD: begin
        act_o   = ACT_L_TICK;
        state_d = ST_FIN;
      end
      ST_FIN: begin
        act_o   = ACT_FIN;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != ST_IDLE);

endmodule

// ===== rtl/tsm_datapath.sv =====
// entry memory, index registers, multiplier and shift-subtract divider
module tsm_datapath #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tsm_pkg::dp_act_e    act_i,
  input  logic [1:0]          op_i,
  input  logic [7:0]          sig_num_i,
  input  logic [7:0]          sig_den_i,
  input  logic [19:0]         bar_in_i,
  input  logic [31:0]         tick_in_i,
  input  logic [3:0]          entry_index_i,
  output tsm_pkg::dp_status_t status_o,
  output logic                done_o,
  output logic [7:0]          res_num_o,
  output logic [7:0]          res_den_o,
  output logic [31:0]         res_bar_o,
  output logic [47:0]         res_tick_o,
  output logic [4:0]          entry_count_o,
  output logic                up_to_date_o,
  output logic                error_o
);
  import tsm_pkg::*;

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam entry_t DefEntry = '{num: SigW'(DefSig), den: SigW'(DefSig), bar: '0, tick: '0};

  entry_t mem_q [TABLE_DEPTH];
  entry_t rd_q, tmp_q, sel_q;

  logic [CW-1:0] cnt_q, i_q, j_q, j_m1;
  logic          fresh_q, done_q, err_q;
  op_e           op_q;
  logic [SigW-1:0]    num_q, den_q;
  logic [BarW-1:0]    bar_q;
  logic [InTickW-1:0] tick_q;
  logic [3:0]         idx_q;
  logic [SpanW-1:0]   span_q;
  logic [TickW-1:0]   prod_q;

  logic [DivW-1:0]    dvd_q;
  logic [SpanW:0]     rem_q;
  logic [SpanW-1:0]   dsr_q;
  logic               dneg_q, dzero_q;
  logic [DivCntW-1:0] dcnt_q;

  logic [SigW-1:0]    res_num_q, res_den_q;
  logic [ResBarW-1:0] res_bar_q;
  logic [TickW-1:0]   res_tick_q;

  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  entry_t        wr_data;

  logic [SpanW:0]        rem_sh;
  logic                  q_bit;
  logic signed [DivW-1:0] q_signed, tick_diff;
  logic signed [BarW:0]  bdiff_r, bdiff_l;
  logic signed [BarW+SpanW+1:0] mul_r, mul_l;
  logic                  look_hit, cnt_room;

  assign j_m1     = j_q - CW'(1);
  assign cnt_room = (32'(cnt_q) < TABLE_DEPTH);

  assign rem_sh = {rem_q[SpanW-1:0], dvd_q[DivW-1]};
  assign q_bit  = (rem_sh >= {1'b0, dsr_q});

  assign q_signed  = dzero_q ? '0 : (dneg_q ? -$signed(dvd_q) : $signed(dvd_q));
  assign tick_diff = $signed({17'b0, tick_q}) - $signed({sel_q.tick[TickW-1], sel_q.tick});

  assign bdiff_r = $signed({1'b0, tmp_q.bar}) - $signed({1'b0, sel_q.bar});
  assign bdiff_l = $signed({1'b0, bar_q}) - $signed({1'b0, sel_q.bar});
  assign mul_r   = bdiff_r * $signed({1'b0, span_q});
  assign mul_l   = bdiff_l * $signed({1'b0, dvd_q[SpanW-1:0]});

  assign look_hit = (op_q == OP_BAR_AT_TICK)
                  ? ($signed(rd_q.tick) <= $signed({16'b0, tick_q}))
                  : (rd_q.bar <= bar_q);

  assign status_o = '{
    op:       op_q,
    fresh:    fresh_q,
    cnt_zero: (cnt_q == '0),
    i_lt_cnt: (i_q < cnt_q),
    match:    (rd_q.bar == bar_q),
    gt:       (rd_q.bar > tmp_q.bar),
    j_zero:   (j_q == '0),
    idx_ok:   (32'(idx_q) < 32'(cnt_q)) && (32'(idx_q) < TABLE_DEPTH),
    div_last: (dcnt_q == DivCntW'(DivW - 1))
  };

  // memory port control
  always_comb begin
    wr_en   = 1'b0;
    rd_en   = 1'b0;
    wr_addr = '0;
    rd_addr = '0;
    wr_data = tmp_q;
    unique case (act_i)
      ACT_RD_I: begin
        rd_en   = 1'b1;
        rd_addr = i_q[AW-1:0];
      end
      ACT_RD_JM1: begin
        rd_en   = 1'b1;
        rd_addr = j_m1[AW-1:0];
      end
      ACT_RD_0: begin
        rd_en = 1'b1;
      end
      ACT_RD_IDX: begin
        rd_en   = 1'b1;
        rd_addr = AW'(idx_q);
      end
      ACT_P_CMP: begin
        wr_en   = (rd_q.bar == bar_q);
        wr_addr = i_q[AW-1:0];
        wr_data = '{num: num_q, den: den_q, bar: rd_q.bar, tick: rd_q.tick};
      end
      ACT_P_APP: begin
        wr_en   = cnt_room;
        wr_addr = cnt_q[AW-1:0];
        wr_data = '{num: num_q, den: den_q, bar: bar_q, tick: {16'b0, tick_q}};
      end
      ACT_S_PUT: begin
        wr_en   = 1'b1;
        wr_addr = j_q[AW-1:0];
      end
      ACT_S_CMP: begin
        wr_en   = 1'b1;
        wr_addr = j_q[AW-1:0];
        wr_data = (rd_q.bar > tmp_q.bar) ? rd_q : tmp_q;
      end
      ACT_R_WR: begin
        wr_en   = 1'b1;
        wr_addr = i_q[AW-1:0];
        wr_data = '{num: tmp_q.num, den: tmp_q.den, bar: tmp_q.bar,
                    tick: sel_q.tick + prod_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem_q[rd_addr];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      fresh_q <= 1'b0;
      done_q  <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
    end else begin
      done_q <= (act_i == ACT_FIN);
      case (act_i)
        ACT_LATCH, ACT_L_INIT: i_q <= '0;
        ACT_I_ONE, ACT_RD_0:   i_q <= CW'(1);
        ACT_P_CMP: begin
          if (rd_q.bar == bar_q) fresh_q <= 1'b0;
          else i_q <= i_q + CW'(1);
        end
        ACT_P_APP: begin
          if (cnt_room) begin
            cnt_q   <= cnt_q + CW'(1);
            fresh_q <= 1'b0;
          end
        end
        ACT_S_LDI: j_q <= i_q;
        ACT_S_PUT: i_q <= i_q + CW'(1);
        ACT_S_CMP: begin
          if (rd_q.bar > tmp_q.bar) j_q <= j_m1;
          else i_q <= i_q + CW'(1);
        end
        ACT_R_WR, ACT_L_CMP: i_q <= i_q + CW'(1);
        ACT_SET_FRESH: fresh_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // payload and arithmetic
  always_ff @(posedge clk_i) begin
    case (act_i)
      ACT_LATCH: begin
        op_q       <= op_e'(op_i);
        num_q      <= sig_num_i;
        den_q      <= sig_den_i;
        bar_q      <= bar_in_i;
        tick_q     <= tick_in_i;
        idx_q      <= entry_index_i;
        err_q      <= 1'b0;
        res_num_q  <= '0;
        res_den_q  <= '0;
        res_bar_q  <= '0;
        res_tick_q <= '0;
        sel_q      <= DefEntry;
      end
      ACT_P_APP: if (!cnt_room) err_q <= 1'b1;
      ACT_X_ERR: err_q <= 1'b1;
      ACT_X_OUT: begin
        res_num_q  <= rd_q.num;
        res_den_q  <= rd_q.den;
        res_bar_q  <= ResBarW'(rd_q.bar);
        res_tick_q <= rd_q.tick;
      end
      ACT_S_LDI: tmp_q <= rd_q;
      ACT_R_LD0: sel_q <= rd_q;
      ACT_R_SPAN: begin
        tmp_q  <= rd_q;
        span_q <= SpanW'(BarDivLut[sel_q.den]) * SpanW'(sel_q.num);
      end
      ACT_R_MUL: prod_q <= TickW'(mul_r);
      ACT_R_WR: begin
        sel_q <= '{num: tmp_q.num, den: tmp_q.den, bar: tmp_q.bar,
                   tick: sel_q.tick + prod_q};
      end
      ACT_L_INIT: sel_q <= DefEntry;
      ACT_L_CMP: if (look_hit || (i_q == '0)) sel_q <= rd_q;
      ACT_L_SPAN: begin
        if (op_q == OP_BAR_AT_TICK) span_q <= SpanW'(BarDivLut[sel_q.den]) * SpanW'(sel_q.num);
        else span_q <= SpanW'(sel_q.num) * SpanW'(BarTicks);
      end
      ACT_DIV_START: begin
        rem_q  <= '0;
        dcnt_q <= '0;
        if (op_q == OP_BAR_AT_TICK) begin
          dneg_q  <= tick_diff[DivW-1];
          dvd_q   <= tick_diff[DivW-1] ? DivW'(-tick_diff) : DivW'(tick_diff);
          dsr_q   <= span_q;
          dzero_q <= (span_q == '0);
        end else begin
          dneg_q  <= 1'b0;
          dvd_q   <= DivW'(span_q);
          dsr_q   <= SpanW'(sel_q.den);
          dzero_q <= (sel_q.den == '0);
        end
      end
      ACT_DIV_STEP: begin
        rem_q  <= q_bit ? (rem_sh - {1'b0, dsr_q}) : rem_sh;
        dvd_q  <= {dvd_q[DivW-2:0], q_bit};
        dcnt_q <= dcnt_q + DivCntW'(1);
      end
      ACT_L_BAR: begin
        res_num_q <= sel_q.num;
        res_den_q <= sel_q.den;
        res_bar_q <= ResBarW'($signed({{(DivW-BarW){1'b0}}, sel_q.bar}) + q_signed);
      end
      ACT_L_MUL: begin
        if (dzero_q) prod_q <= '0;
        else prod_q <= TickW'(mul_l);
      end
      ACT_L_TICK: begin
        res_num_q  <= sel_q.num;
        res_den_q  <= sel_q.den;
        res_bar_q  <= ResBarW'(bar_q);
        res_tick_q <= sel_q.tick + prod_q;
      end
      default: ;
    endcase
  end

  assign done_o        = done_q;
  assign res_num_o     = res_num_q;
  assign res_den_o     = res_den_q;
  assign res_bar_o     = res_bar_q;
  assign res_tick_o    = res_tick_q;
  assign entry_count_o = 5'(cnt_q);
  assign up_to_date_o  = fresh_q;
  assign error_o       = err_q;

endmodule

// ===== tb/sv/time_signature_map_core_tb.sv =====
// testbench for the time signature map: random and directed commands checked against a predictor
module time_signature_map_core_tb;
  import tsm_pkg::*;

  typedef struct {
    logic [7:0]  num;
    logic [7:0]  den;
    logic [31:0] bar;
    logic [47:0] tick;
    logic [4:0]  cnt;
    logic        fresh;
    logic        err;
  } sig_result_t;

  class sig_map_scoreboard;
    logic [7:0]  tbl_num [16];
    logic [7:0]  tbl_den [16];
    logic [19:0] tbl_bar [16];
    longint      tbl_tick [16];
    int          used;
    bit          sorted;
    sig_result_t pending [$];
    int          errors;
    int          checked;
    int          n_err_flag;

    function new();
      used = 0;
      sorted = 0;
      errors = 0;
      checked = 0;
      n_err_flag = 0;
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    function longint wrap48(longint v);
      logic [47:0] w;
      w = v[47:0];
      return longint'($signed(w));
    endfunction

    function longint bar_len_div(logic [7:0] n, logic [7:0] d);
      if (d == 0) return 0;
      return longint'((1920 / int'(d)) * int'(n));
    endfunction

    function longint bar_len_mul(logic [7:0] n, logic [7:0] d);
      if (d == 0) return 0;
      return longint'((int'(n) * 1920) / int'(d));
    endfunction

    function void reorder();
      logic [7:0]  n, d;
      logic [19:0] b;
      longint      t;
      int          j;
      if (used == 0) return;
      for (int i = 1; i < used; i++) begin
        n = tbl_num[i]; d = tbl_den[i]; b = tbl_bar[i]; t = tbl_tick[i];
        j = i;
        while (j > 0 && tbl_bar[j-1] > b) begin
          tbl_num[j] = tbl_num[j-1]; tbl_den[j] = tbl_den[j-1];
          tbl_bar[j] = tbl_bar[j-1]; tbl_tick[j] = tbl_tick[j-1];
          j--;
        end
        tbl_num[j] = n; tbl_den[j] = d; tbl_bar[j] = b; tbl_tick[j] = t;
      end
      for (int i = 1; i < used; i++)
        tbl_tick[i] = wrap48(tbl_tick[i-1] + (longint'(tbl_bar[i]) - longint'(tbl_bar[i-1]))
                             * bar_len_div(tbl_num[i-1], tbl_den[i-1]));
      sorted = 1;
    endfunction

    function void note_input(op_e op, logic [7:0] num, logic [7:0] den, logic [19:0] bar,
                             logic [31:0] tick, logic [3:0] idx);
      sig_result_t r;
      longint      q, len, rb, rt;
      int          k;
      bit          hit;
      q = longint'(tick);
      rb = 0; rt = 0;
      r.num = 0; r.den = 0; r.err = 0;
      case (op)
        OP_PUSH: begin
          hit = 0;
          for (int i = 0; i < used; i++)
            if (!hit && tbl_bar[i] == bar) begin
              tbl_num[i] = num; tbl_den[i] = den; hit = 1;
            end
          if (hit) sorted = 0;
          else if (used < 16) begin
            tbl_num[used] = num; tbl_den[used] = den;
            tbl_bar[used] = bar; tbl_tick[used] = q;
            used++;
            sorted = 0;
          end else r.err = 1;
        end
        OP_BAR_AT_TICK: begin
          if (!sorted) reorder();
          if (used == 0) begin
            r.num = 4; r.den = 4; rb = q / 1920;
          end else begin
            k = 0;
            for (int i = used - 1; i >= 0; i--)
              if (tbl_tick[i] <= q) begin k = i; break; end
            r.num = tbl_num[k]; r.den = tbl_den[k];
            len = bar_len_div(r.num, r.den);
            rb = longint'(tbl_bar[k]);
            if (len != 0) rb += (q - tbl_tick[k]) / len;
          end
        end
        OP_TICK_AT_BAR: begin
          if (!sorted) reorder();
          rb = longint'(bar);
          if (used == 0) begin
            r.num = 4; r.den = 4; rt = longint'(bar) * 1920;
          end else begin
            k = 0;
            for (int i = used - 1; i >= 0; i--)
              if (tbl_bar[i] <= bar) begin k = i; break; end
            r.num = tbl_num[k]; r.den = tbl_den[k];
            rt = tbl_tick[k] + (longint'(bar) - longint'(tbl_bar[k]))
                 * bar_len_mul(r.num, r.den);
          end
        end
        default: begin
          if (int'(idx) < used) begin
            r.num = tbl_num[idx]; r.den = tbl_den[idx];
            rb = longint'(tbl_bar[idx]); rt = tbl_tick[idx];
          end else r.err = 1;
        end
      endcase
      r.bar = rb[31:0];
      r.tick = rt[47:0];
      r.cnt = used[4:0];
      r.fresh = sorted;
      if (r.err) n_err_flag++;
      pending.push_back(r);
    endfunction

    task check_result(logic [7:0] num, logic [7:0] den, logic [31:0] bar,
                      logic [47:0] tick, logic [4:0] cnt, logic fresh, logic err);
      sig_result_t e;
      if (pending.size() == 0) begin
        report("result beat with nothing expected");
        return;
      end
      e = pending.pop_front();
      checked++;
      if (num !== e.num) report($sformatf("res_num %0d, expected %0d", num, e.num));
      if (den !== e.den) report($sformatf("res_den %0d, expected %0d", den, e.den));
      if (bar !== e.bar) report($sformatf("res_bar %h, expected %h", bar, e.bar));
      if (tick !== e.tick) report($sformatf("res_tick %h, expected %h", tick, e.tick));
      if (cnt !== e.cnt) report($sformatf("entry_count %0d, expected %0d", cnt, e.cnt));
      if (fresh !== e.fresh) report($sformatf("up_to_date %b, expected %b", fresh, e.fresh));
      if (err !== e.err) report($sformatf("error %b, expected %b", err, e.err));
    endtask
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        start = 0;
  logic        busy;
  logic [1:0]  op_i = '0;
  logic [7:0]  sig_num_i = '0;
  logic [7:0]  sig_den_i = '0;
  logic [19:0] bar_in_i = '0;
  logic [31:0] tick_in_i = '0;
  logic [3:0]  entry_index_i = '0;
  logic        done_o;
  logic [7:0]  res_num_o;
  logic [7:0]  res_den_o;
  logic [31:0] res_bar_o;
  logic [47:0] res_tick_o;
  logic [4:0]  entry_count_o;
  logic        up_to_date_o;
  logic        error_o;

  sig_map_scoreboard sb = new();
  int sent = 0;

  always begin
    #2 clk_i = 1;
    #2 clk_i = 0;
  end

  time_signature_map_core dut (.*);

  always @(posedge clk_i) begin
    if (rst_ni && done_o)
      sb.check_result(res_num_o, res_den_o, res_bar_o, res_tick_o, entry_count_o,
                      up_to_date_o, error_o);
  end

  task automatic idle_gap();
    int g;
    g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 80) : $urandom_range(0, 2);
    if (g > 0) begin
      start <= 0;
      repeat (g) @(negedge clk_i);
    end
  endtask

  // called at a falling edge; returns at a falling edge after the beat is taken
  task automatic send_cmd(op_e op, logic [7:0] num, logic [7:0] den, logic [19:0] bar,
                          logic [31:0] tick, logic [3:0] idx);
    start <= 1;
    op_i <= op;
    sig_num_i <= num;
    sig_den_i <= den;
    bar_in_i <= bar;
    tick_in_i <= tick;
    entry_index_i <= idx;
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    sb.note_input(op, num, den, bar, tick, idx);
    sent++;
    @(negedge clk_i);
    idle_gap();
  endtask

  task automatic send_random();
    op_e         op;
    logic [19:0] bar;
    logic [31:0] tick;
    logic [7:0]  num, den;
    op = op_e'($urandom_range(0, 3));
    bar = ($urandom_range(0, 7) == 0) ? 20'($urandom) : 20'($urandom_range(0, 40));
    case ($urandom_range(0, 3))
      0: tick = $urandom;
      1: tick = 32'($urandom_range(0, 80000));
      default: tick = 32'($urandom_range(0, 40)) * 1920;
    endcase
    num = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(1, 12));
    case ($urandom_range(0, 9))
      0: den = 8'($urandom);
      1: den = 0;
      default: den = 8'(1 << $urandom_range(0, 5));
    endcase
    send_cmd(op, num, den, bar, tick, 4'($urandom));
  endtask

  initial begin
    #40000000;
    $display("FAIL time_signature_map_core");
    $finish;
  end

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);
    // empty table behavior
    send_cmd(OP_BAR_AT_TICK, 0, 0, 0, 32'hFFFF_FFFF, 0);
    send_cmd(OP_TICK_AT_BAR, 0, 0, 20'hFFFFF, 0, 0);
    send_cmd(OP_READ, 0, 0, 0, 0, 0);
    send_cmd(OP_READ, 0, 0, 0, 0, 4'hF);
    // unordered pushes, then lookups that sort
    send_cmd(OP_PUSH, 3, 4, 8, 100, 0);
    send_cmd(OP_PUSH, 255, 255, 20'hFFFFF, 32'hFFFF_FFFF, 0);
    send_cmd(OP_PUSH, 7, 8, 2, 5000, 0);
    send_cmd(OP_PUSH, 5, 0, 4, 0, 0);
    send_cmd(OP_PUSH, 0, 1, 0, 300, 0);
    send_cmd(OP_READ, 0, 0, 0, 0, 1);
    send_cmd(OP_BAR_AT_TICK, 0, 0, 0, 0, 0);
    send_cmd(OP_BAR_AT_TICK, 0, 0, 0, 32'hFFFF_FFFF, 0);
    send_cmd(OP_BAR_AT_TICK, 0, 0, 0, 12000, 0);
    send_cmd(OP_TICK_AT_BAR, 0, 0, 5, 0, 0);
    send_cmd(OP_TICK_AT_BAR, 0, 0, 20'hFFFFF, 0, 0);
    // update of an existing bar keeps its tick
    send_cmd(OP_PUSH, 6, 8, 2, 99999, 0);
    send_cmd(OP_READ, 0, 0, 0, 0, 1);
    send_cmd(OP_TICK_AT_BAR, 0, 0, 3, 0, 0);
    send_cmd(OP_READ, 0, 0, 0, 0, 2);
    send_cmd(OP_READ, 0, 0, 0, 0, 5);
    repeat (1830) send_random();
    start <= 0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    $display("sent %0d commands, checked %0d results, %0d with the error flag expected",
             sent, sb.checked, sb.n_err_flag);
    if (sb.errors == 0) begin
      $display("PASS time_signature_map_core");
    end else begin
      $display("FAIL time_signature_map_core");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/tsm_pkg.sv
rtl/tsm_ctrl.sv
rtl/tsm_datapath.sv
rtl/time_signature_map_core.sv
tb/sv/time_signature_map_core_tb.sv
